>>> rtl/splru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package splru_pkg;

    // Pool size and stamp width
    localparam int SLOTS     = 16;
    localparam int TICK_BITS = 32;

    // Derived widths
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_GET   = 2'd1,
        MODE_TOUCH = 2'd2,
        MODE_FREE  = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_ALLOC,
        ST_GET,
        ST_DONE
    } state_t;

    // Request and response payloads
    typedef struct packed {
        mode_t              mode;
        logic [7:0]         slot_index;
        logic signed [31:0] payload;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [7:0]         granted_slot;
        logic signed [31:0] read_data;
        logic [31:0]        read_stamp;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/splru_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module splru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/slot_pool_lru_evict_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: alloc runs IDLE, SCAN, ALLOC, DONE (one slot of the stamp RAM read per
// cycle while scanning); a get of a used in-range slot runs IDLE, EXEC, GET, DONE;
// touch, free and any erroring get run IDLE, EXEC, DONE. One request at a time:
// the next request transfer comes only back in IDLE, and DONE holds while an older
// response still waits in the output register.
// Reset: async active low; pool empty, tick zero, no response pending.
module slot_pool_lru_evict_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire splru_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output splru_pkg::rsp_t      rsp
);

    localparam int IDX_W = splru_pkg::IDX_W;
    localparam int CNT_W = splru_pkg::CNT_W;
    localparam int TW    = splru_pkg::TICK_BITS;

    splru_pkg::state_t state_reg, state_next;

    splru_pkg::req_t   req_reg, req_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [splru_pkg::SLOTS-1:0] used_reg, used_next;

    // Scan bookkeeping
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_free_reg, found_free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [TW-1:0]     best_stamp_reg, best_stamp_next;

    splru_pkg::rsp_t   result_reg, result_next;
    splru_pkg::rsp_t   rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // RAM ports
    logic              data_we, stamp_we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [31:0]       data_rd;
    logic [TW-1:0]     stamp_rd;

    logic              req_fire, rsp_fire;
    logic              in_range_new, in_range;
    logic [IDX_W-1:0]  req_idx;
    logic [IDX_W-1:0]  pick_idx;
    logic              scan_last;

    splru_ram #(.WIDTH(32), .DEPTH(splru_pkg::SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (waddr),
        .wdata (req_reg.payload),
        .raddr (raddr),
        .rdata (data_rd)
    );

    splru_ram #(.WIDTH(TW), .DEPTH(splru_pkg::SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (waddr),
        .wdata (tick_reg),
        .raddr (raddr),
        .rdata (stamp_rd)
    );

    // Handshakes and decode
    assign req_ready    = (state_reg == splru_pkg::ST_IDLE);
    assign req_fire     = req_valid && req_ready;
    assign rsp_fire     = rsp_valid_reg && rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign in_range_new = ({1'b0, req.slot_index} < 9'(splru_pkg::SLOTS));
    assign in_range     = ({1'b0, req_reg.slot_index} < 9'(splru_pkg::SLOTS));
    assign req_idx      = req_reg.slot_index[IDX_W-1:0];
    assign pick_idx     = found_free_reg ? free_idx_reg : best_idx_reg;
    assign scan_last    = cmp_valid_reg && (cmp_idx_reg == IDX_W'(splru_pkg::SLOTS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            splru_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.mode == splru_pkg::MODE_ALLOC) ?
                                 splru_pkg::ST_SCAN : splru_pkg::ST_EXEC;
                end
            end
            splru_pkg::ST_EXEC:
            begin
                if (req_reg.mode == splru_pkg::MODE_GET && in_range && used_reg[req_idx])
                begin
                    state_next = splru_pkg::ST_GET;
                end
                else
                begin
                    state_next = splru_pkg::ST_DONE;
                end
            end
            splru_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = splru_pkg::ST_ALLOC;
                end
            end
            splru_pkg::ST_ALLOC: state_next = splru_pkg::ST_DONE;
            splru_pkg::ST_GET:   state_next = splru_pkg::ST_DONE;
            splru_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = splru_pkg::ST_IDLE;
                end
            end
            default: state_next = splru_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        tick_next       = tick_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_free_next = found_free_reg;
        free_idx_next   = free_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        result_next     = result_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        data_we         = 1'b0;
        stamp_we        = 1'b0;
        waddr           = req_idx;
        raddr           = req_idx;

        case (state_reg)
            splru_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_next        = req;
                    ptr_next        = '0;
                    found_free_next = 1'b0;
                    result_next     = '0;
                    // tick advances for alloc and in-range touch
                    if (req.mode == splru_pkg::MODE_ALLOC ||
                        (req.mode == splru_pkg::MODE_TOUCH && in_range_new))
                    begin
                        tick_next = tick_reg + TW'(1);
                    end
                end
            end
            splru_pkg::ST_EXEC:
            begin
                if (!in_range)
                begin
                    result_next.status = splru_pkg::STATUS_ERR;
                end
                else
                begin
                    case (req_reg.mode)
                        splru_pkg::MODE_GET:
                        begin
                            if (!used_reg[req_idx])
                            begin
                                result_next.status = splru_pkg::STATUS_ERR;
                            end
                        end
                        splru_pkg::MODE_TOUCH: stamp_we = 1'b1;
                        splru_pkg::MODE_FREE:  used_next[req_idx] = 1'b0;
                        default: ;
                    endcase
                end
            end
            splru_pkg::ST_SCAN:
            begin
                // Issue one stamp read per cycle, compare the one from last cycle
                raddr = ptr_reg[IDX_W-1:0];
                if (ptr_reg < CNT_W'(splru_pkg::SLOTS))
                begin
                    ptr_next       = ptr_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = ptr_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg)
                begin
                    if (!found_free_reg && !used_reg[cmp_idx_reg])
                    begin
                        found_free_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == '0 || stamp_rd < best_stamp_reg)
                    begin
                        best_idx_next   = cmp_idx_reg;
                        best_stamp_next = stamp_rd;
                    end
                end
            end
            splru_pkg::ST_ALLOC:
            begin
                waddr                    = pick_idx;
                data_we                  = 1'b1;
                stamp_we                 = 1'b1;
                used_next[pick_idx]      = 1'b1;
                result_next.granted_slot = 8'(pick_idx);
            end
            splru_pkg::ST_GET:
            begin
                result_next.read_data  = data_rd;
                result_next.read_stamp = 32'(stamp_rd);
            end
            splru_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = result_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= splru_pkg::ST_IDLE;
            tick_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            ptr_reg       <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_free_reg <= found_free_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        result_reg     <= result_next;
        rsp_reg        <= rsp_next;
    end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4 * splru_pkg::SLOTS + 8;
    localparam int IDLE_PCT = 28;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    splru_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    splru_pkg::rsp_t rsp;

    // Pool shadow: used marks, data words, stamps and the tick
    logic                            pool_used [splru_pkg::SLOTS];
    logic [31:0]                     pool_data [splru_pkg::SLOTS];
    logic [splru_pkg::TICK_BITS-1:0] pool_stamp [splru_pkg::SLOTS];
    logic [splru_pkg::TICK_BITS-1:0] pool_tick;

    splru_pkg::rsp_t pending_rsp_q[$];
    int   mismatch_count = 0;
    int   stall_cycles = 0;
    bit   steady = 1'b0;

    slot_pool_lru_evict_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow pool and return the response it should give
    function automatic splru_pkg::rsp_t pool_apply(input splru_pkg::req_t r);
        splru_pkg::rsp_t res;
        int   pick;
        int   i;
        res = '0;
        if (r.mode == splru_pkg::MODE_ALLOC)
        begin
            pool_tick = pool_tick + 1'b1;
            pick = splru_pkg::SLOTS;
            for (i = 0; i < splru_pkg::SLOTS; i++)
            begin
                if (!pool_used[i] && pick == splru_pkg::SLOTS)
                begin
                    pick = i;
                end
            end
            // Pool full: oldest stamp goes, lowest index wins a tie
            if (pick == splru_pkg::SLOTS)
            begin
                pick = 0;
                for (i = 1; i < splru_pkg::SLOTS; i++)
                begin
                    if (pool_stamp[i] < pool_stamp[pick])
                    begin
                        pick = i;
                    end
                end
            end
            pool_used[pick] = 1'b1;
            pool_data[pick] = r.payload;
            pool_stamp[pick] = pool_tick;
            res.granted_slot = pick[7:0];
        end
        else if (r.slot_index >= splru_pkg::SLOTS)
        begin
            res.status = splru_pkg::STATUS_ERR;
        end
        else
        begin
            case (r.mode)
                splru_pkg::MODE_GET:
                begin
                    if (pool_used[r.slot_index])
                    begin
                        res.read_data = pool_data[r.slot_index];
                        res.read_stamp = 32'(pool_stamp[r.slot_index]);
                    end
                    else
                    begin
                        res.status = splru_pkg::STATUS_ERR;
                    end
                end
                splru_pkg::MODE_TOUCH:
                begin
                    // a free slot is restamped too and stays free
                    pool_tick = pool_tick + 1'b1;
                    pool_stamp[r.slot_index] = pool_tick;
                end
                default:
                begin
                    pool_used[r.slot_index] = 1'b0;
                end
            endcase
        end
        return res;
    endfunction

    // Drive one request; called at a falling edge, returns at a falling edge
    task automatic send_req(input splru_pkg::mode_t mode, input int idx,
                            input logic [31:0] word);
        splru_pkg::req_t item;
        item.mode = mode;
        item.slot_index = idx[7:0];
        item.payload = word;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        pending_rsp_q.push_back(pool_apply(item));
        @(negedge clk);
    endtask

    // Random traffic with the given operation mix; free takes the remainder
    task automatic run_mix(input int count, input int alloc_pct, input int get_pct,
                           input int touch_pct);
        int    pick;
        int    idx;
        splru_pkg::mode_t mode;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < alloc_pct)
            begin
                mode = splru_pkg::MODE_ALLOC;
            end
            else if (pick < alloc_pct + get_pct)
            begin
                mode = splru_pkg::MODE_GET;
            end
            else if (pick < alloc_pct + get_pct + touch_pct)
            begin
                mode = splru_pkg::MODE_TOUCH;
            end
            else
            begin
                mode = splru_pkg::MODE_FREE;
            end
            // mostly in range, some out of range up to the field maximum
            if ($urandom_range(99) < 90)
            begin
                idx = $urandom_range(splru_pkg::SLOTS - 1);
            end
            else
            begin
                idx = $urandom_range(255, splru_pkg::SLOTS);
            end
            send_req(mode, idx, $urandom);
        end
    endtask

    // Edge cases: errors, free-slot touch and free, fill, payload extremes, eviction
    task automatic test_directed();
        send_req(splru_pkg::MODE_GET, 0, 32'h0);
        send_req(splru_pkg::MODE_GET, 255, 32'hFFFF_FFFF);
        send_req(splru_pkg::MODE_TOUCH, splru_pkg::SLOTS, 32'h0);
        send_req(splru_pkg::MODE_FREE, 200, 32'h0);
        send_req(splru_pkg::MODE_TOUCH, 3, 32'h0);
        send_req(splru_pkg::MODE_FREE, 5, 32'h0);
        send_req(splru_pkg::MODE_ALLOC, 255, 32'h7FFF_FFFF);
        send_req(splru_pkg::MODE_ALLOC, 0, 32'h8000_0000);
        send_req(splru_pkg::MODE_ALLOC, 0, 32'hFFFF_FFFF);
        send_req(splru_pkg::MODE_ALLOC, 0, 32'h0000_0000);
        for (int n = 4; n < splru_pkg::SLOTS; n++)
        begin
            send_req(splru_pkg::MODE_ALLOC, 0, $urandom);
        end
        // slot 0 made recent, so the full-pool alloc should evict slot 1
        send_req(splru_pkg::MODE_TOUCH, 0, 32'h0);
        send_req(splru_pkg::MODE_ALLOC, 0, 32'h1234_5678);
        send_req(splru_pkg::MODE_GET, 1, 32'h0);
    endtask

    // Balanced churn: pool fills and empties
    task automatic test_churn();
        run_mix(450, 30, 30, 15);
    endtask

    // Back-to-back transfers with no idling on either side
    task automatic test_back_to_back();
        steady = 1'b1;
        run_mix(200, 30, 30, 20);
        steady = 1'b0;
    endtask

    // Alloc-heavy traffic with rare frees keeps the pool full and evicting
    task automatic test_eviction();
        run_mix(250, 45, 25, 25);
    endtask

    // Response-side stalls
    always @(negedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Response checker
    always @(posedge clk)
    begin
        splru_pkg::rsp_t want;
        string bad;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected response status=%0d slot=%0d data=%0d stamp=%0d",
                         $time, rsp.status, rsp.granted_slot, rsp.read_data,
                         rsp.read_stamp);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                bad = "";
                if (rsp.status !== want.status) bad = {bad, " status"};
                if (rsp.granted_slot !== want.granted_slot) bad = {bad, " granted_slot"};
                if (rsp.read_data !== want.read_data) bad = {bad, " read_data"};
                if (rsp.read_stamp !== want.read_stamp) bad = {bad, " read_stamp"};
                if (bad != "")
                begin
                    mismatch_count++;
                    $display({"%0t: mismatch in%s: expected status=%0d slot=%0d ",
                              "data=%0d stamp=%0d, got status=%0d slot=%0d ",
                              "data=%0d stamp=%0d"},
                             $time, bad, want.status, want.granted_slot, want.read_data,
                             want.read_stamp, rsp.status, rsp.granted_slot,
                             rsp.read_data, rsp.read_stamp);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("slot_pool_lru_evict_top regression: fail");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < splru_pkg::SLOTS; i++)
        begin
            pool_used[i] = 1'b0;
            pool_data[i] = '0;
            pool_stamp[i] = '0;
        end
        pool_tick = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_churn();
        test_back_to_back();
        test_eviction();
        req_valid <= 1'b0;

        // drain, then let any trailing activity settle
        while (pending_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("slot_pool_lru_evict_top regression: pass");
        end
        else
        begin
            $display("slot_pool_lru_evict_top regression: fail");
        end
        $finish;
    end

endmodule

>>> slot_pool_lru_evict_top.f
rtl/splru_pkg.sv
rtl/splru_ram.sv
rtl/slot_pool_lru_evict_top.sv
test/tb.sv
